>>> rtl/frgf_pkg.sv
// ----------------------------------------------------------------------------
// frgf_pkg
// Shared types and constants for the font ROM glyph fetcher.
// ----------------------------------------------------------------------------
`default_nettype none

package frgf_pkg;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  localparam int unsigned BURST_LEN = 16;

  localparam logic [5:0]  WIDE_BYTES   = 6'd32;
  localparam logic [5:0]  NARROW_BYTES = 6'd16;
  localparam logic [5:0]  SPACE_BYTES  = 6'd0;

  localparam logic [7:0]  ROM_READ_CMD = 8'h03;

  localparam logic [15:0] SPACE_FW  = 16'hA3A0;
  localparam logic [15:0] SPACE_NUL = 16'h0000;

  localparam logic [7:0]  HANZI_HI_MIN = 8'hB0;
  localparam logic [7:0]  HANZI_HI_MAX = 8'hF7;
  localparam logic [7:0]  SYM_HI_MIN   = 8'hA1;
  localparam logic [7:0]  SYM_HI_MAX   = 8'hA3;
  localparam logic [7:0]  GB_LO_MIN    = 8'hA1;
  localparam logic [13:0] GB_ROW_LEN   = 14'd94;
  localparam logic [13:0] HANZI_BASE   = 14'd846;

  localparam logic [15:0] FW_MIN     = 16'hA3A1;
  localparam logic [15:0] FW_MAX     = 16'hA3FE;
  localparam logic [23:0] FW_BASE    = 24'h03B7D0;
  localparam logic [15:0] ASCII_MIN  = 16'h0020;
  localparam logic [15:0] ASCII_MAX  = 16'h007E;
  localparam logic [23:0] ASCII_BASE = 24'h03B7C0;

  typedef struct packed {
    logic       chip_select_n;
    logic       mosi;
    logic [7:0] glyph_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [5:0] glyph_len;
    logic       busy_res;
  } res_t;

  function automatic logic [7:0] tri_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd2:    b = 8'h80;
      4'd3:    b = 8'hC0;
      4'd4:    b = 8'h80;
      4'd8:    b = 8'h02;
      4'd9:    b = 8'h03;
      4'd10:   b = 8'h03;
      4'd11:   b = 8'h03;
      4'd12:   b = 8'h03;
      4'd13:   b = 8'h03;
      4'd14:   b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/frgf_if.sv
// ----------------------------------------------------------------------------
// frgf_if
// Valid/ready channels of the glyph fetcher: requests, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface frgf_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] char_code;
  logic        wide_glyph;
  logic        miso;

  modport source (output valid, cmd, char_code, wide_glyph, miso, input ready);
  modport sink   (input valid, cmd, char_code, wide_glyph, miso, output ready);
endinterface

interface frgf_res_if;
  logic       valid;
  logic       ready;
  logic       chip_select_n;
  logic       mosi;
  logic [7:0] glyph_byte;
  logic       byte_valid;
  logic       last_byte;
  logic [5:0] glyph_len;
  logic       busy_res;

  modport source (output valid, chip_select_n, mosi, glyph_byte, byte_valid,
                  last_byte, glyph_len, busy_res, input ready);
  modport sink   (input valid, chip_select_n, mosi, glyph_byte, byte_valid,
                  last_byte, glyph_len, busy_res, output ready);
  modport mon    (input valid, ready, chip_select_n, mosi, glyph_byte, byte_valid,
                  last_byte, glyph_len, busy_res);
endinterface

interface frgf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/font_rom_glyph_fetch_spi.sv
// ----------------------------------------------------------------------------
// font_rom_glyph_fetch_spi
// Glyph fetcher: maps a GB2312/ASCII code to a font ROM address and reads
// the glyph over a bit-serial SPI port, one bit per tick item.
// ----------------------------------------------------------------------------
// Each tick item, and each request taken while no read runs, puts its result
// in a single output register: one item per clock while the result side keeps
// up and no burst runs. A space or triangle request yields 16 results from it,
// one per clock as res.ready allows; req.ready is low until the last is loaded.
// A ROM read is 1 request plus 32 send ticks plus 8 ticks per glyph byte.
// Requests during a read are taken and dropped. cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module font_rom_glyph_fetch_spi (
  input wire logic clk,
  input wire logic rst,
  frgf_req_if.sink   req,
  frgf_cfg_if.sink   cfg,
  frgf_res_if.source res
);
  import frgf_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_RECV
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [31:0] out_shift, out_shift_next;
  logic [7:0]  in_shift, in_shift_next;
  logic [5:0]  bytes_left, bytes_left_next;
  logic [5:0]  current_len, current_len_next;
  logic [15:0] triangle_code;

  logic        burst_active, burst_active_next;
  logic        burst_tri, burst_tri_next;
  logic [3:0]  burst_idx, burst_idx_next;

  logic        out_valid;
  res_t        res_q, res_d;
  logic        load;
  logic        out_free;
  logic        in_acc;
  logic [23:0] rom_addr;
  logic [7:0]  rx_byte;
  logic [5:0]  left_dec;

  frgf_addr_map u_addr_map (
    .char_code  (req.char_code),
    .wide_glyph (req.wide_glyph),
    .rom_addr   (rom_addr)
  );

  assign out_free  = !out_valid || res.ready;
  assign req.ready = out_free && !burst_active;
  assign in_acc    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rx_byte   = {in_shift[6:0], req.miso};
  assign left_dec  = (bytes_left != 6'd0) ? bytes_left - 6'd1 : 6'd0;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    out_shift_next    = out_shift;
    in_shift_next     = in_shift;
    bytes_left_next   = bytes_left;
    current_len_next  = current_len;
    burst_active_next = burst_active;
    burst_tri_next    = burst_tri;
    burst_idx_next    = burst_idx;
    load              = 1'b0;
    res_d             = '0;
    res_d.chip_select_n = 1'b1;

    if (burst_active && out_free) begin
      load             = 1'b1;
      res_d.glyph_byte = burst_tri ? tri_byte(burst_idx) : 8'h00;
      res_d.byte_valid = 1'b1;
      res_d.last_byte  = (burst_idx == 4'(BURST_LEN - 1));
      res_d.glyph_len  = current_len;
      burst_idx_next   = burst_idx + 4'd1;
      if (burst_idx == 4'(BURST_LEN - 1)) begin
        burst_active_next = 1'b0;
      end
    end else if (in_acc) begin
      if (req.cmd == CMD_REQUEST) begin
        if (phase == PH_IDLE) begin
          load = 1'b1;
          if (req.char_code == SPACE_FW || req.char_code == SPACE_NUL ||
              req.char_code == triangle_code) begin
            burst_tri_next    = !(req.char_code == SPACE_FW ||
                                  req.char_code == SPACE_NUL);
            current_len_next  = burst_tri_next ? NARROW_BYTES : SPACE_BYTES;
            burst_active_next = 1'b1;
            burst_idx_next    = 4'd1;
            res_d.glyph_byte  = burst_tri_next ? tri_byte(4'd0) : 8'h00;
            res_d.byte_valid  = 1'b1;
          end else begin
            current_len_next    = req.wide_glyph ? WIDE_BYTES : NARROW_BYTES;
            out_shift_next      = {ROM_READ_CMD, rom_addr};
            in_shift_next       = 8'h00;
            bit_count_next      = 5'd0;
            bytes_left_next     = current_len_next;
            phase_next          = PH_SEND;
            res_d.chip_select_n = 1'b0;
            res_d.busy_res      = 1'b1;
          end
          res_d.glyph_len = current_len_next;
        end
      end else begin
        load            = 1'b1;
        res_d.glyph_len = current_len;
        case (phase)
          PH_SEND: begin
            res_d.chip_select_n = 1'b0;
            res_d.busy_res      = 1'b1;
            res_d.mosi          = out_shift[31];
            out_shift_next      = {out_shift[30:0], 1'b0};
            bit_count_next      = bit_count + 5'd1;
            if (bit_count == 5'd31) begin
              phase_next = PH_RECV;
            end
          end
          PH_RECV: begin
            res_d.chip_select_n = 1'b0;
            res_d.busy_res      = 1'b1;
            in_shift_next       = rx_byte;
            bit_count_next      = bit_count + 5'd1;
            if (bit_count[2:0] == 3'd7) begin
              bit_count_next   = 5'd0;
              bytes_left_next  = left_dec;
              res_d.glyph_byte = rx_byte;
              res_d.byte_valid = 1'b1;
              res_d.last_byte  = (left_dec == 6'd0);
              if (left_dec == 6'd0) begin
                phase_next = PH_IDLE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= 5'd0;
      bytes_left    <= 6'd0;
      current_len   <= 6'd0;
      triangle_code <= 16'd0;
      burst_active  <= 1'b0;
      burst_tri     <= 1'b0;
      burst_idx     <= 4'd0;
      out_valid     <= 1'b0;
    end else begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      bytes_left   <= bytes_left_next;
      current_len  <= current_len_next;
      burst_active <= burst_active_next;
      burst_tri    <= burst_tri_next;
      burst_idx    <= burst_idx_next;
      if (cfg.valid && cfg.ready) begin
        triangle_code <= cfg.data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_shift <= out_shift_next;
    in_shift  <= in_shift_next;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res.valid         = out_valid;
  assign res.chip_select_n = res_q.chip_select_n;
  assign res.mosi          = res_q.mosi;
  assign res.glyph_byte    = res_q.glyph_byte;
  assign res.byte_valid    = res_q.byte_valid;
  assign res.last_byte     = res_q.last_byte;
  assign res.glyph_len     = res_q.glyph_len;
  assign res.busy_res      = res_q.busy_res;

endmodule

`default_nettype wire

>>> rtl/frgf_addr_map.sv
// ----------------------------------------------------------------------------
// frgf_addr_map
// Maps a character code to its 24-bit font ROM address.
// ----------------------------------------------------------------------------
`default_nettype none

module frgf_addr_map (
  input  wire logic [15:0] char_code,
  input  wire logic        wide_glyph,
  output logic      [23:0] rom_addr
);
  import frgf_pkg::*;

  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [7:0]  hi_off;
  logic [7:0]  lo_off;
  logic [13:0] row_base;
  logic [13:0] glyph_idx;
  logic [15:0] nar_off;

  assign hi = char_code[15:8];
  assign lo = char_code[7:0];

  always_comb begin
    hi_off    = 8'd0;
    lo_off    = lo - GB_LO_MIN;
    row_base  = 14'd0;
    glyph_idx = 14'd0;
    nar_off   = 16'd0;
    rom_addr  = 24'd0;
    if (wide_glyph) begin
      if (hi inside {[HANZI_HI_MIN:HANZI_HI_MAX]} && lo >= GB_LO_MIN) begin
        hi_off    = hi - HANZI_HI_MIN;
        row_base  = 14'(hi_off[6:0]) * GB_ROW_LEN;
        glyph_idx = row_base + 14'(lo_off) + HANZI_BASE;
        rom_addr  = {5'd0, glyph_idx, 5'd0};
      end else if (hi inside {[SYM_HI_MIN:SYM_HI_MAX]} && lo >= GB_LO_MIN) begin
        hi_off    = hi - SYM_HI_MIN;
        row_base  = 14'(hi_off[1:0]) * GB_ROW_LEN;
        glyph_idx = row_base + 14'(lo_off);
        rom_addr  = {5'd0, glyph_idx, 5'd0};
      end
    end else begin
      if (char_code inside {[FW_MIN:FW_MAX]}) begin
        nar_off  = char_code - FW_MIN;
        rom_addr = FW_BASE + {13'd0, nar_off[6:0], 4'd0};
      end else if (char_code inside {[ASCII_MIN:ASCII_MAX]}) begin
        nar_off  = char_code - ASCII_MIN;
        rom_addr = ASCII_BASE + {13'd0, nar_off[6:0], 4'd0};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/frgf_checker.sv
// ----------------------------------------------------------------------------
// frgf_checker
// Port-level checks on the result channel of the glyph fetcher.
// ----------------------------------------------------------------------------
`default_nettype none

module frgf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       chip_select_n,
  input wire logic       mosi,
  input wire logic [7:0] glyph_byte,
  input wire logic       byte_valid,
  input wire logic       last_byte,
  input wire logic       busy_res
);

  // stalled result holds its glyph byte
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(glyph_byte))
    else $error("result changed while stalled");

  // chip select is asserted exactly while a read is under way
  a_cs_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> chip_select_n != busy_res)
    else $error("chip select and busy disagree");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && last_byte |-> byte_valid)
    else $error("last byte without a glyph byte");

  a_mosi_send: assert property (@(posedge clk) disable iff (rst)
    res_valid && mosi |-> busy_res && !byte_valid)
    else $error("mosi driven outside the send phase");

endmodule

bind font_rom_glyph_fetch_spi frgf_checker u_frgf_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .chip_select_n (res.chip_select_n),
  .mosi          (res.mosi),
  .glyph_byte    (res.glyph_byte),
  .byte_valid    (res.byte_valid),
  .last_byte     (res.last_byte),
  .busy_res      (res.busy_res)
);

`default_nettype wire
